// File: rtl/sds_pkg.sv
// Shared types and constants for the sphere decoder search block.
package sds_pkg;

  localparam int MAX_DIM      = 16;
  localparam int DIM_W        = 5;
  localparam int LVL_W        = 4;
  localparam int MAT_DEPTH    = (MAX_DIM * (MAX_DIM + 1)) / 2;
  localparam int MAT_AW       = 8;
  localparam int STEP_W       = 21;
  localparam int SEARCH_LIMIT = 1048576;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = 2;

  typedef enum logic [1:0] {
    KIND_MAT   = 2'd0,
    KIND_RHS   = 2'd1,
    KIND_START = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         slot;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic  avail;
    item_t item;
  } q_head_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK,
    S_CHK_W,
    S_ENT,
    S_ENT_D,
    S_SUM_A,
    S_SUM_M,
    S_SUM_ACC,
    S_S,
    S_DIV,
    S_CTR,
    S_G1,
    S_G2,
    S_G3,
    S_SQ,
    S_EVAL,
    S_ZIG,
    S_ZIG_D,
    S_OUT
  } state_t;

endpackage

// File: rtl/sphere_decoder_search.sv
// Top level of the sphere decoder search block: config register and front/back glue.
//
// Usage. Drive kind, slot and value with start high; the transaction is taken
// when busy is low. Kind 0 loads matrix entry slot (packed row-major upper
// triangle for the current dimension), kind 1 loads right-hand entry slot,
// kind 2 starts a search, kind 3 is dropped. Transactions enter a four-entry
// queue, so loads stream one per cycle; the queue drains one per cycle only while the engine is idle.
// A start runs the search in the engine: a check of all n diagonal entries, then
// per level entry a dot product with one multiplier and the 64-step radix-2
// divider, and per zig-zag or leaf step a two-part gap multiply, a square
// and a compare. The search stops after 2^20
// steps at most. It then drives n results, one per cycle, each marked by
// valid for a single cycle; the receiver cannot stall them. Element n-1
// carries last and the best residual. busy is high only while the queue is
// full, so transactions keep queueing while a search runs.
// The dimension register sits at byte address 0 of the APB port, reset 16.
// A synchronous reset empties the queue, idles the engine and sets radius
// to all ones; the stores keep whatever they hold until written.
module sphere_decoder_search
  import sds_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [7:0]         slot,
  input  logic signed [31:0] value,
  output logic               valid,
  output logic [3:0]         position,
  output logic signed [15:0] estimate,
  output logic               last,
  output logic [63:0]        residual,
  output logic               bad_diagonal,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [DIM_W-1:0] dimension;
  logic [DIM_W-1:0] wdim;
  q_head_t          head;
  logic             pop;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(dimension);

  // clamp the written dimension into 1..MAX_DIM
  always_comb begin
    wdim = pwdata[DIM_W-1:0];
    if (wdim == '0)                  wdim = DIM_W'(1);
    else if (wdim > DIM_W'(MAX_DIM)) wdim = DIM_W'(MAX_DIM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_W'(MAX_DIM);
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      dimension <= wdim;
    end
  end

  sds_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .kind  (kind),
    .slot  (slot),
    .value (value),
    .head  (head),
    .pop   (pop)
  );

  sds_back u_back (
    .clk          (clk),
    .rst          (rst),
    .n            (dimension),
    .head         (head),
    .pop          (pop),
    .valid        (valid),
    .position     (position),
    .estimate     (estimate),
    .last         (last),
    .residual     (residual),
    .bad_diagonal (bad_diagonal)
  );

`ifndef NO_ASSERTIONS
  // advance position by one within a run
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    valid && !last |=> valid && position == $past(position) + 4'd1)
    else $error("result run broke its position order");

  // drop to idle after the last element
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    valid && last |=> !valid)
    else $error("result after last element");

  // hold estimates at zero on a bad diagonal
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    valid && bad_diagonal |-> estimate == 16'sd0 && (!last || residual == '1))
    else $error("bad diagonal result carries data");
`endif

endmodule

// File: rtl/sds_front.sv
// Front end: accepts transactions, drops unknown kinds, queues the rest.
module sds_front
  import sds_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [7:0]         slot,
  input  logic signed [31:0] value,
  output q_head_t            head,
  input  logic               pop
);

  item_t               q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                push;
  logic                do_pop;

  assign busy   = (count == (QPTR_W+1)'(QDEPTH));
  assign push   = start && !busy && (kind_t'(kind) != KIND_NONE);
  assign do_pop = pop && (count != '0);

  assign head.avail = (count != '0);
  assign head.item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{kind: kind_t'(kind), slot: slot, value: value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/sds_back.sv
// Back end: stores, depth-first enumeration engine and result sequencing.
module sds_back
  import sds_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [DIM_W-1:0]   n,
  input  q_head_t            head,
  output logic               pop,
  output logic               valid,
  output logic [3:0]         position,
  output logic signed [15:0] estimate,
  output logic               last,
  output logic [63:0]        residual,
  output logic               bad_diagonal
);

  localparam logic signed [53:0] S_MAX = 54'sd140737488355327;
  localparam logic signed [53:0] S_MIN = -54'sd140737488355327;

  function automatic logic [MAT_AW-1:0] pidx(input logic [DIM_W-1:0] nn,
                                             input logic [LVL_W-1:0] k,
                                             input logic [LVL_W-1:0] j);
    logic [9:0] a;
    a = 10'(nn) * 10'(k) + 10'(j) - ((10'(k) * (10'(k) + 10'd1)) >> 1);
    return a[MAT_AW-1:0];
  endfunction

  state_t state, state_next;

  logic signed [31:0] mat [MAT_DEPTH];
  logic signed [31:0] rhs [MAX_DIM];
  logic signed [31:0] mat_q, rhs_q;
  logic [MAT_AW-1:0]  mat_addr;
  logic               mat_we, rhs_we;

  logic signed [15:0] tp  [MAX_DIM];
  logic signed [15:0] bp  [MAX_DIM];
  logic signed [15:0] dir [MAX_DIM];
  logic signed [31:0] ctr [MAX_DIM];
  logic [63:0]        pr  [MAX_DIM];

  logic [LVL_W-1:0]   level, idx;
  logic [DIM_W-1:0]   jj;
  logic signed [53:0] acc;
  logic signed [47:0] prod;
  logic signed [31:0] rkk, gap;
  logic [63:0]        dvd, quo, g2, radius;
  logic [31:0]        rem, dvs;
  logic               qneg, bad;
  logic [5:0]         dcnt;
  logic signed [48:0] p1;
  logic signed [49:0] p2;
  logic [STEP_W-1:0]  steps;

  // datapath helpers
  logic [32:0]        rem_sh;
  logic signed [33:0] diff;
  logic signed [31:0] cc;
  logic signed [33:0] zz, cc34;
  logic signed [15:0] zc;
  logic signed [50:0] gfull;
  logic signed [31:0] gsat;
  logic [31:0]        ag;
  logic [64:0]        npw;
  logic [63:0]        np;
  logic signed [53:0] sfull, sc, smag;
  logic signed [16:0] zsum;
  logic signed [17:0] dnew;
  logic signed [15:0] dcur;
  logic               last_lvl;

  assign last_lvl = (level == LVL_W'(n - 5'd1));

  // memories
  always_ff @(posedge clk) begin
    if (mat_we) mat[head.item.slot] <= head.item.value;
    mat_q <= mat[mat_addr];
  end

  always_ff @(posedge clk) begin
    if (rhs_we) rhs[head.item.slot[3:0]] <= head.item.value;
    rhs_q <= rhs[level];
  end

  // combinational datapath
  always_comb begin
    rem_sh = {rem, dvd[63]};
    diff   = 34'(ctr[level]) - {{2{tp[level][15]}}, tp[level], 16'b0};
    if (qneg) begin
      cc = (quo > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-$signed(quo));
    end else begin
      cc = (quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(quo);
    end
    cc34 = 34'(cc);
    if (cc34 >= 0) zz = (cc34 + 34'sd32768) >>> 16;
    else           zz = -((-cc34 + 34'sd32768) >>> 16);
    zc = (zz > 34'sd32767) ? 16'sd32767 : 16'(zz);
    gfull = 51'(p2) + 51'(p1 >>> 16);
    if (gfull > 51'sd2147483647)       gsat = 32'sh7FFF_FFFF;
    else if (gfull < -51'sd2147483648) gsat = 32'sh8000_0000;
    else                               gsat = 32'(gfull);
    ag    = gap[31] ? 32'(-gap) : 32'(gap);
    npw   = {1'b0, pr[level]} + {1'b0, g2};
    np    = npw[64] ? '1 : npw[63:0];
    sfull = 54'(rhs_q) - acc;
    if (sfull > S_MAX)      sc = S_MAX;
    else if (sfull < S_MIN) sc = S_MIN;
    else                    sc = sfull;
    smag = sc[53] ? -sc : sc;
    dcur = dir[level];
    zsum = 17'(tp[level]) + 17'(dcur);
    dnew = (dcur > 0) ? (-18'(dcur) - 18'sd1) : (-18'(dcur) + 18'sd1);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (head.avail && head.item.kind == KIND_START) state_next = S_CHK;
      end
      S_CHK:   state_next = S_CHK_W;
      S_CHK_W: begin
        if (idx == LVL_W'(n - 5'd1))
          state_next = (bad || mat_q == 0) ? S_OUT : S_ENT;
        else
          state_next = S_CHK;
      end
      S_ENT:     state_next = S_ENT_D;
      S_ENT_D:   state_next = S_SUM_A;
      S_SUM_A:   state_next = (jj < n) ? S_SUM_M : S_S;
      S_SUM_M:   state_next = S_SUM_ACC;
      S_SUM_ACC: state_next = S_SUM_A;
      S_S:       state_next = S_DIV;
      S_DIV:     state_next = (dcnt == 6'd63) ? S_CTR : S_DIV;
      S_CTR:     state_next = S_G1;
      S_G1:      state_next = S_G2;
      S_G2:      state_next = S_G3;
      S_G3:      state_next = S_SQ;
      S_SQ:      state_next = S_EVAL;
      S_EVAL: begin
        if (steps == STEP_W'(SEARCH_LIMIT)) state_next = S_OUT;
        else if (np < radius)               state_next = (level != 0) ? S_ENT : S_ZIG;
        else                                state_next = last_lvl ? S_OUT : S_ZIG;
      end
      S_ZIG:   state_next = S_ZIG_D;
      S_ZIG_D: state_next = S_G1;
      S_OUT:   state_next = (idx == LVL_W'(n - 5'd1)) ? S_IDLE : S_OUT;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    mat_we   = 1'b0;
    rhs_we   = 1'b0;
    mat_addr = pidx(n, level, level);
    case (state)
      S_IDLE: begin
        pop    = head.avail;
        mat_we = head.avail && head.item.kind == KIND_MAT &&
                 head.item.slot < 8'(MAT_DEPTH);
        rhs_we = head.avail && head.item.kind == KIND_RHS &&
                 head.item.slot < 8'(MAX_DIM);
      end
      S_CHK:   mat_addr = pidx(n, idx, idx);
      S_SUM_A: mat_addr = pidx(n, level, jj[LVL_W-1:0]);
      default: mat_addr = pidx(n, level, level);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      radius <= '1;
      level  <= '0;
      gap    <= '0;
      bad    <= 1'b0;
      for (int i = 0; i < MAX_DIM; i++) begin
        tp[i]  <= '0;
        bp[i]  <= '0;
        dir[i] <= '0;
        ctr[i] <= '0;
        pr[i]  <= '0;
      end
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (head.avail && head.item.kind == KIND_START) begin
            for (int i = 0; i < MAX_DIM; i++) begin
              tp[i]  <= '0;
              bp[i]  <= '0;
              dir[i] <= '0;
              ctr[i] <= '0;
              pr[i]  <= '0;
            end
            radius <= '1;
            gap    <= '0;
            level  <= '0;
            bad    <= 1'b0;
            steps  <= '0;
            idx    <= '0;
          end
        end
        S_CHK_W: begin
          if (mat_q == 0) bad <= 1'b1;
          if (idx == LVL_W'(n - 5'd1)) begin
            idx   <= '0;
            level <= LVL_W'(n - 5'd1);
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_ENT_D: begin
          rkk <= mat_q;
          jj  <= 5'(level) + 5'd1;
          acc <= '0;
        end
        S_SUM_M:   prod <= mat_q * tp[jj[LVL_W-1:0]];
        S_SUM_ACC: begin
          acc <= acc + 54'(prod);
          jj  <= jj + 5'd1;
        end
        S_S: begin
          dvd  <= {smag[47:0], 16'b0};
          dvs  <= rkk[31] ? 32'(-rkk) : 32'(rkk);
          qneg <= sc[53] ^ rkk[31];
          rem  <= '0;
          quo  <= '0;
          dcnt <= '0;
        end
        S_DIV: begin
          dvd  <= {dvd[62:0], 1'b0};
          dcnt <= dcnt + 6'd1;
          if (rem_sh >= {1'b0, dvs}) begin
            rem <= 32'(rem_sh - {1'b0, dvs});
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh[31:0];
            quo <= {quo[62:0], 1'b0};
          end
        end
        S_CTR: begin
          ctr[level] <= cc;
          tp[level]  <= zc;
          dir[level] <= (cc34 > $signed({{2{zc[15]}}, zc, 16'b0})) ? 16'sd1 : -16'sd1;
        end
        S_G1: p1 <= rkk * $signed({1'b0, diff[15:0]});
        S_G2: p2 <= rkk * $signed(diff[33:16]);
        S_G3: gap <= gsat;
        S_SQ: g2 <= ag * ag;
        S_EVAL: begin
          if (steps == STEP_W'(SEARCH_LIMIT)) begin
            idx <= '0;
          end else begin
            steps <= steps + 1'b1;
            if (np < radius) begin
              if (level != 0) begin
                level <= level - 1'b1;
                pr[level - 1'b1] <= np;
              end else begin
                radius <= np;
                for (int i = 0; i < MAX_DIM; i++) bp[i] <= tp[i];
              end
            end else if (last_lvl) begin
              idx <= '0;
            end else begin
              level <= level + 1'b1;
            end
          end
        end
        S_ZIG: begin
          if (zsum > 17'sd32767)       tp[level] <= 16'sd32767;
          else if (zsum < -17'sd32768) tp[level] <= -16'sd32768;
          else                         tp[level] <= 16'(zsum);
          dir[level] <= (dnew > 18'sd32767) ? 16'sd32767 : 16'(dnew);
        end
        S_ZIG_D: rkk <= mat_q;
        S_OUT: begin
          valid        <= 1'b1;
          position     <= idx;
          estimate     <= bad ? 16'sd0 : bp[idx];
          last         <= (idx == LVL_W'(n - 5'd1));
          residual     <= (idx == LVL_W'(n - 5'd1)) ? radius : 64'd0;
          bad_diagonal <= bad;
          idx          <= idx + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: tb/sv/sphere_decoder_search_tb.sv
// Self-checking testbench for the sphere decoder search block.
module sphere_decoder_search_tb;
  import sds_pkg::*;

  // Pending transaction for the driver; hold_for_drain makes the driver
  // wait until every expected result has come before issuing it.
  typedef struct {
    kind_t              kind;
    logic [7:0]         slot;
    logic signed [31:0] value;
    bit                 hold_for_drain;
  } txn_t;

  typedef struct {
    logic [3:0]         position;
    logic signed [15:0] estimate;
    logic               last;
    logic [63:0]        residual;
    logic               bad_diagonal;
  } element_t;

  localparam longint S_MAX = 64'sd140737488355327;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam longint I32_MAX = 64'sd2147483647;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         kind = KIND_NONE;
  logic [7:0]         slot = '0;
  logic signed [31:0] value = '0;
  logic               valid;
  logic [3:0]         position;
  logic signed [15:0] estimate;
  logic               last;
  logic [63:0]        residual;
  logic               bad_diagonal;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  sphere_decoder_search u_dut (.*);

  always #6 clk = ~clk;

  txn_t     pending_txns[$];
  element_t expected_solution[$];
  int       mismatch_count = 0;
  int       searches_run = 0;
  int       solutions_checked = 0;
  int       queued_items = 0;
  int       idle_gap = 0;
  bit       burst_mode = 1'b0;

  // Shadow copy of the block: stores, dimension and search state.
  int              matrix_q[MAT_DEPTH];
  int              rhs_q[MAX_DIM];
  int              shadow_dim = 16;
  int              trial_z[MAX_DIM];
  int              best_z[MAX_DIM];
  int              step_d[MAX_DIM];
  int              center_q[MAX_DIM];
  longint unsigned partial_r[MAX_DIM];
  int              gap_q;

  function automatic longint clamp64(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic int packed_slot(int n, int k, int j);
    return n * k + j - (k * (k + 1)) / 2;
  endfunction

  function automatic int level_gap(int n, int k);
    longint rkk, diff, prod;
    rkk = matrix_q[packed_slot(n, k, k)];
    diff = longint'(center_q[k]) - longint'(trial_z[k]) * 65536;
    prod = rkk * diff;
    return int'(clamp64(prod >>> 16, I32_MIN, I32_MAX));
  endfunction

  // Project the partial solution onto level k: center, rounded point, gap.
  function automatic void descend_to(int n, int k);
    longint acc, s, q, cc, zz;
    acc = 0;
    for (int j = k + 1; j < n; j++)
      acc += longint'(matrix_q[packed_slot(n, k, j)]) * longint'(trial_z[j]);
    s = clamp64(longint'(rhs_q[k]) - acc, -S_MAX, S_MAX);
    q = (s * 65536) / longint'(matrix_q[packed_slot(n, k, k)]);
    cc = clamp64(q, I32_MIN, I32_MAX);
    center_q[k] = int'(cc);
    if (cc >= 0) zz = (cc + 32768) >>> 16;
    else zz = -((-cc + 32768) >>> 16);
    trial_z[k] = int'(clamp64(zz, -32768, 32767));
    gap_q = level_gap(n, k);
    step_d[k] = (cc > longint'(trial_z[k]) * 65536) ? 1 : -1;
  endfunction

  function automatic void zigzag_at(int n, int k);
    longint d;
    d = step_d[k];
    trial_z[k] = int'(clamp64(longint'(trial_z[k]) + d, -32768, 32767));
    gap_q = level_gap(n, k);
    step_d[k] = int'(clamp64((d > 0) ? -d - 1 : -d + 1, -32768, 32767));
  endfunction

  // Run the whole enumeration for one start and queue its n elements.
  function automatic void predict_solution();
    int              n, lvl, steps;
    bit              bad;
    longint unsigned radius_q, g2, np;
    element_t        e;
    n = shadow_dim;
    bad = 1'b0;
    radius_q = '1;
    steps = 0;
    for (int k = 0; k < MAX_DIM; k++) begin
      trial_z[k] = 0; best_z[k] = 0; step_d[k] = 0; center_q[k] = 0; partial_r[k] = 0;
    end
    gap_q = 0;
    for (int k = 0; k < n; k++)
      if (matrix_q[packed_slot(n, k, k)] == 0) bad = 1'b1;
    if (!bad) begin
      lvl = n - 1;
      descend_to(n, lvl);
      while (steps < SEARCH_LIMIT) begin
        g2 = longint'(gap_q) * longint'(gap_q);
        np = partial_r[lvl] + g2;
        if (np < partial_r[lvl]) np = '1;
        steps++;
        if (np < radius_q) begin
          if (lvl != 0) begin
            lvl--;
            partial_r[lvl] = np;
            descend_to(n, lvl);
          end else begin
            radius_q = np;
            best_z = trial_z;
            zigzag_at(n, 0);
          end
        end else begin
          if (lvl == n - 1) break;
          lvl++;
          zigzag_at(n, lvl);
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      e.position = k[3:0];
      e.estimate = bad ? 16'sd0 : best_z[k][15:0];
      e.last = (k == n - 1);
      e.residual = (k == n - 1) ? radius_q : 64'd0;
      e.bad_diagonal = bad;
      expected_solution.push_back(e);
    end
    searches_run++;
  endfunction

  // Apply one accepted transaction to the shadow state.
  function automatic void absorb_txn(logic [1:0] k, logic [7:0] s, logic signed [31:0] v);
    case (k)
      KIND_MAT: begin
        if (s < MAT_DEPTH) matrix_q[s] = v;
      end
      KIND_RHS: begin
        if (s < MAX_DIM) rhs_q[s] = v;
      end
      KIND_START: begin
        predict_solution();
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Driver: issue the next transaction once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) absorb_txn(kind, slot, value);
      if (idle_gap > 0) begin
        idle_gap <= idle_gap - 1;
        start <= 1'b0;
      end else if (pending_txns.size() > 0 &&
                   !(pending_txns[0].hold_for_drain &&
                     (start || expected_solution.size() > 0))) begin
        kind <= pending_txns[0].kind;
        slot <= pending_txns[0].slot;
        value <= pending_txns[0].value;
        void'(pending_txns.pop_front());
        start <= 1'b1;
        idle_gap <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h (element %0d)", what, got, want, position);
    mismatch_count++;
  endtask

  // Monitor: every strobe must match the oldest outstanding element.
  always @(posedge clk) begin
    element_t e;
    if (!rst && valid) begin
      if (expected_solution.size() == 0) begin
        report_mismatch("unexpected result", {60'd0, position}, 64'd0);
      end else begin
        e = expected_solution.pop_front();
        solutions_checked++;
        if (position !== e.position) report_mismatch("position", position, e.position);
        if (estimate !== e.estimate)
          report_mismatch("estimate", {48'd0, estimate}, {48'd0, e.estimate});
        if (last !== e.last) report_mismatch("last", last, e.last);
        if (residual !== e.residual) report_mismatch("residual", residual, e.residual);
        if (bad_diagonal !== e.bad_diagonal)
          report_mismatch("bad_diagonal", bad_diagonal, e.bad_diagonal);
      end
    end
  end

  task automatic push_txn(kind_t k, int s, logic signed [31:0] v, bit drain = 1'b0);
    txn_t t;
    t.kind = k;
    t.slot = s[7:0];
    t.value = v;
    t.hold_for_drain = drain;
    pending_txns.push_back(t);
    queued_items++;
  endtask

  // Wait until the block is idle, then let in-flight loads settle.
  task automatic wait_idle();
    while (pending_txns.size() > 0 || start || expected_solution.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_dimension(logic [31:0] d);
    int eff;
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= '0; pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    eff = d & 31;
    shadow_dim = (eff < 1) ? 1 : ((eff > MAX_DIM) ? MAX_DIM : eff);
  endtask

  task automatic push_noise();
    case ($urandom_range(0, 2))
      0: push_txn(KIND_NONE, $urandom_range(0, 255), $urandom);
      1: push_txn(KIND_MAT, $urandom_range(MAT_DEPTH, 255), $urandom);
      default: push_txn(KIND_RHS, $urandom_range(MAX_DIM, 255), $urandom);
    endcase
  endtask

  // Load a complete problem for the current dimension in shuffled order,
  // then start; wild uses full-range values (single unknown only).
  task automatic load_problem(bit wild, bit zero_diag, bit drain);
    int n, m, tmp, zk;
    int order[$];
    logic signed [31:0] v;
    n = shadow_dim;
    m = n * (n + 1) / 2;
    zk = $urandom_range(0, n - 1);
    for (int i = 0; i < m + n; i++) order.push_back(i);
    for (int i = order.size() - 1; i > 0; i--) begin
      tmp = $urandom_range(0, i);
      {order[i], order[tmp]} = {order[tmp], order[i]};
    end
    foreach (order[i]) begin
      if (order[i] >= m) begin
        v = wild ? $urandom : $signed($urandom_range(0, 32'h100_0000)) - 32'sh80_0000;
        push_txn(KIND_RHS, order[i] - m, v);
      end else begin
        int k, j;
        k = 0;
        while (packed_slot(n, k + 1, k + 1) <= order[i] && k + 1 < n) k++;
        j = order[i] - packed_slot(n, k, 0);
        if (wild) v = $urandom;
        else if (j == k)
          v = ($urandom_range(0, 1) ? 1 : -1) *
              $signed((n >= 8) ? $urandom_range(32'h2_0000, 32'h4_0000)
                               : $urandom_range(32'h8000, 32'h4_0000));
        else
          v = (n >= 8) ? $signed($urandom_range(0, 32'h8000)) - 32'sh4000
                       : $signed($urandom_range(0, 32'h1_0000)) - 32'sh8000;
        if (j == k && (zero_diag && k == zk || v == 0)) v = zero_diag && k == zk ? 0 : 1;
        push_txn(KIND_MAT, order[i], v);
      end
      if ($urandom_range(0, 19) == 0) push_noise();
    end
    push_txn(KIND_START, $urandom_range(0, 255), $urandom, drain);
  endtask

  task automatic single_problem(logic signed [31:0] r, logic signed [31:0] y);
    push_txn(KIND_MAT, 0, r);
    push_txn(KIND_RHS, 0, y);
    push_txn(KIND_START, 0, 32'sd0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: one unknown, extreme entries, half rounding, zero diagonal,
    // ignored loads and the unused kind.
    write_dimension(32'd0);
    single_problem(32'sh8000_0000, 32'sh7fff_ffff);
    single_problem(32'sh0000_0001, 32'sh7fff_ffff);
    single_problem(32'sh7fff_ffff, 32'sh8000_0000);
    single_problem(32'sh0000_0001, 32'sh8000_0000);
    single_problem(32'sh0002_0000, 32'sh0001_0000);
    push_txn(KIND_MAT, 0, 32'sd0);
    push_txn(KIND_MAT, MAT_DEPTH, 32'sh1234_5678);
    push_txn(KIND_MAT, 255, 32'sh0001_0000);
    push_txn(KIND_RHS, 255, 32'sh7fff_ffff);
    push_txn(KIND_NONE, 255, 32'shffff_ffff);
    push_txn(KIND_START, 0, 32'sd0, 1'b1);
    wait_idle();

    // Largest dimension once, through the clamp on an out-of-range value.
    write_dimension(32'hffff_ffff);
    load_problem(1'b0, 1'b0, 1'b0);
    wait_idle();

    // Random phases: mostly small problems with random content.
    while (queued_items < 190) begin
      int pick;
      burst_mode = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 30) write_dimension(32'd1);
      else if (pick < 85) write_dimension($urandom_range(2, 4));
      else if (pick < 95) write_dimension($urandom_range(5, 8));
      else write_dimension(32'd17);
      repeat ($urandom_range(1, 3)) begin
        load_problem(shadow_dim == 1 && $urandom_range(0, 1), $urandom_range(0, 9) == 0,
                     $urandom_range(0, 4) == 0);
      end
      wait_idle();
    end

    wait_idle();
    repeat (100) @(posedge clk);
    $display("covered %0d searches over dimensions 1 to 16, %0d solution elements checked",
             searches_run, solutions_checked);
    if (mismatch_count == 0 && expected_solution.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(12 * 20_000_000);
    $display("timeout waiting for results");
    $display("FAILED: results differ");
    $finish;
  end

endmodule
